### rtl/pcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_pkg
// Shared constants, types and palette table for the palette hold and
// crossfade block.
// ----------------------------------------------------------------------------
package pcf_pkg;

    localparam int PALETTE_ENTRIES = 10;
    localparam int FADE_MS         = 2000;
    localparam int HOLD_RESET      = 3000;

    localparam int ROM_SIZE  = 10;
    localparam int TIMER_W   = 17;
    localparam int TIMER_MAX = (1 << TIMER_W) - 1;
    localparam int DT_W      = 10;
    localparam int HOLD_W    = 16;
    localparam int INDEX_W   = 4;
    localparam int CHAN_W    = 8;
    localparam int CHANNELS  = 6;

    localparam int SLOT_W = $clog2(ROM_SIZE);
    // blend weight runs 0..FADE_MS
    localparam int TW     = $clog2(FADE_MS + 1);
    // weighted sum c*(F-t) + n*t stays below 256*F
    localparam int NUM_W  = $clog2(255 * FADE_MS + 1);
    // exact floor division by FADE_MS through a rounded-up reciprocal
    localparam int  DIV_SHIFT = NUM_W + $clog2(FADE_MS);
    localparam longint RECIP  = ((64'd1 << DIV_SHIFT) + FADE_MS - 1) / FADE_MS;
    localparam int  RECIP_W   = $clog2(RECIP + 1);
    localparam int  PROD_W    = NUM_W + RECIP_W;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_HOLD_TIME = '0;

    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [CHAN_W-1:0]  chan_t;
    typedef logic [CHANNELS*CHAN_W-1:0] pair_t;

    // registered with the phase update of the same tick, ready for blending
    typedef struct packed {
        slot_t            cur_slot;
        slot_t            nxt_slot;
        logic [TW-1:0]    weight;
        logic             fade;
        index_t           index;
    } pcf_step_t;

    // {first r, g, b, second r, g, b}
    localparam pair_t PALETTE_ROM [ROM_SIZE] = '{
        {8'd184, 8'd0,   8'd184, 8'd107, 8'd0,   8'd184},
        {8'd107, 8'd0,   8'd184, 8'd31,  8'd0,   8'd184},
        {8'd31,  8'd0,   8'd184, 8'd0,   8'd46,  8'd184},
        {8'd0,   8'd46,  8'd184, 8'd0,   8'd123, 8'd184},
        {8'd0,   8'd123, 8'd184, 8'd0,   8'd184, 8'd169},
        {8'd7,   8'd154, 8'd90,  8'd46,  8'd184, 8'd82},
        {8'd169, 8'd184, 8'd0,   8'd184, 8'd123, 8'd0},
        {8'd184, 8'd123, 8'd0,   8'd184, 8'd46,  8'd0},
        {8'd184, 8'd46,  8'd0,   8'd184, 8'd0,   8'd31},
        {8'd184, 8'd28,  8'd70,  8'd154, 8'd0,   8'd89}
    };

    function automatic index_t next_index(input index_t idx);
        index_t n;
        begin
            n = idx + 1'b1;
            next_index = ({1'b0, n} >= (INDEX_W + 1)'(PALETTE_ENTRIES)) ? '0 : n;
        end
    endfunction

    // index mod ROM_SIZE, index is below twice the table size
    function automatic slot_t rom_slot(input index_t idx);
        begin
            if ({1'b0, idx} >= (INDEX_W + 1)'(ROM_SIZE))
                rom_slot = SLOT_W'(idx - INDEX_W'(ROM_SIZE));
            else
                rom_slot = SLOT_W'(idx);
        end
    endfunction

endpackage

### rtl/pcf_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_sequencer
// Phase timer, hold/fade phase and palette index; registers one step
// word per accepted tick.
// ----------------------------------------------------------------------------
module pcf_sequencer
    import pcf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [DT_W-1:0]    elapsed_ms,
    input  logic [HOLD_W-1:0]  hold_time,
    output pcf_step_t          step
);

    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic               fade_reg, fade_next;
    index_t             index_reg, index_next;
    pcf_step_t          step_reg, step_next;

    logic [TIMER_W:0]   sum;
    logic [TIMER_W-1:0] sat;
    logic               blend;

    always_comb
    begin
        sum = {1'b0, timer_reg} + (TIMER_W + 1)'(elapsed_ms);
        sat = (sum > (TIMER_W + 1)'(TIMER_MAX)) ? TIMER_W'(TIMER_MAX) : sum[TIMER_W-1:0];

        timer_next = sat;
        fade_next  = fade_reg;
        index_next = index_reg;
        blend      = 1'b0;

        if (!fade_reg)
        begin
            if (sat > TIMER_W'(hold_time))
            begin
                timer_next = '0;
                fade_next  = 1'b1;
            end
        end
        else if (sat > TIMER_W'(FADE_MS))
        begin
            timer_next = '0;
            fade_next  = 1'b0;
            index_next = next_index(index_reg);
        end
        else
        begin
            blend = 1'b1;
        end

        step_next.cur_slot = rom_slot(index_next);
        step_next.nxt_slot = rom_slot(next_index(index_next));
        // weight zero leaves the current color untouched
        step_next.weight   = blend ? sat[TW-1:0] : '0;
        step_next.fade     = fade_next;
        step_next.index    = index_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg <= '0;
            fade_reg  <= 1'b0;
            index_reg <= '0;
        end
        else if (accept)
        begin
            timer_reg <= timer_next;
            fade_reg  <= fade_next;
            index_reg <= index_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            step_reg <= step_next;
    end

    assign step = step_reg;

endmodule

### rtl/pcf_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_blend
// Two-stage color mix: weighted sum per channel, then exact division by
// the fade length through a reciprocal multiply.
// ----------------------------------------------------------------------------
module pcf_blend
    import pcf_pkg::*;
(
    input  logic       clk,
    input  pcf_step_t  step,
    input  logic       load_mix,
    input  logic       load_out,
    output pair_t      colors,
    output logic       fading,
    output index_t     palette_index
);

    logic [NUM_W-1:0]  mix_reg  [CHANNELS];
    logic [NUM_W-1:0]  mix_next [CHANNELS];
    logic              fade_mix_reg;
    index_t            index_mix_reg;

    chan_t             chan_reg  [CHANNELS];
    chan_t             chan_next [CHANNELS];
    logic              fade_out_reg;
    index_t            index_out_reg;

    pair_t             cur_pair;
    pair_t             nxt_pair;
    logic [TW-1:0]     keep;
    logic [PROD_W-1:0] prod [CHANNELS];

    always_comb
    begin
        cur_pair = PALETTE_ROM[step.cur_slot];
        nxt_pair = PALETTE_ROM[step.nxt_slot];
        keep     = TW'(FADE_MS) - step.weight;
        for (int j = 0; j < CHANNELS; j++)
        begin
            mix_next[j] = NUM_W'(cur_pair[(CHANNELS-1-j)*CHAN_W +: CHAN_W]) * NUM_W'(keep)
                        + NUM_W'(nxt_pair[(CHANNELS-1-j)*CHAN_W +: CHAN_W])
                        * NUM_W'(step.weight);
        end
    end

    always_comb
    begin
        for (int j = 0; j < CHANNELS; j++)
        begin
            prod[j]      = PROD_W'(mix_reg[j]) * PROD_W'(RECIP);
            chan_next[j] = prod[j][DIV_SHIFT +: CHAN_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_mix)
        begin
            mix_reg       <= mix_next;
            fade_mix_reg  <= step.fade;
            index_mix_reg <= step.index;
        end
        if (load_out)
        begin
            chan_reg      <= chan_next;
            fade_out_reg  <= fade_mix_reg;
            index_out_reg <= index_mix_reg;
        end
    end

    always_comb
    begin
        for (int j = 0; j < CHANNELS; j++)
            colors[(CHANNELS-1-j)*CHAN_W +: CHAN_W] = chan_reg[j];
    end

    assign fading        = fade_out_reg;
    assign palette_index = index_out_reg;

endmodule

### rtl/palette_hold_and_crossfade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_hold_and_crossfade
// Steps through a table of color pairs, holding each pair and then
// crossfading to the next one as ticks of elapsed time arrive.
// ----------------------------------------------------------------------------
// path: an accepted tick passes the step register, mix register and
//   result register before its word shows in result_valid
// throughput: one tick per cycle while tick_stall is low; while a finished
//   word waits on result_stall the step and mix registers still take up to two more ticks
// reset: rst_n clears timer, phase, index and valid bits; hold_time
//   returns to 3000 ms
// ----------------------------------------------------------------------------
module palette_hold_and_crossfade
    import pcf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,

    input  logic                  tick_valid,
    output logic                  tick_stall,
    input  logic [DT_W-1:0]       elapsed_ms,

    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [CHAN_W-1:0]     first_red,
    output logic [CHAN_W-1:0]     first_green,
    output logic [CHAN_W-1:0]     first_blue,
    output logic [CHAN_W-1:0]     second_red,
    output logic [CHAN_W-1:0]     second_green,
    output logic [CHAN_W-1:0]     second_blue,
    output logic                  fading,
    output logic [INDEX_W-1:0]    palette_index
);

    logic [HOLD_W-1:0] hold_time_reg;
    logic              cfg_write;

    logic              step_valid_reg;
    logic              mix_valid_reg;
    logic              out_valid_reg;
    logic              out_ready, load_out, load_mix, step_ready, accept;

    pcf_step_t         step;
    pair_t             colors;

    // configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                    && (paddr[APB_ADDR_W-1:2] == REG_HOLD_TIME);
    assign prdata    = (paddr[APB_ADDR_W-1:2] == REG_HOLD_TIME)
                     ? APB_DATA_W'(hold_time_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_time_reg <= HOLD_W'(HOLD_RESET);
        else if (cfg_write)
            hold_time_reg <= pwdata[HOLD_W-1:0];
    end

    // pipeline flow: a stage moves when the one after it is empty or moving
    assign out_ready  = !out_valid_reg || !result_stall;
    assign load_out   = mix_valid_reg && out_ready;
    assign load_mix   = step_valid_reg && (!mix_valid_reg || load_out);
    assign step_ready = !step_valid_reg || load_mix;
    assign accept     = tick_valid && step_ready;
    assign tick_stall = !step_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_valid_reg <= 1'b0;
            mix_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            step_valid_reg <= accept || (step_valid_reg && !load_mix);
            mix_valid_reg  <= load_mix || (mix_valid_reg && !load_out);
            out_valid_reg  <= load_out || (out_valid_reg && result_stall);
        end
    end

    pcf_sequencer u_sequencer (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .elapsed_ms (elapsed_ms),
        .hold_time  (hold_time_reg),
        .step       (step)
    );

    pcf_blend u_blend (
        .clk           (clk),
        .step          (step),
        .load_mix      (load_mix),
        .load_out      (load_out),
        .colors        (colors),
        .fading        (fading),
        .palette_index (palette_index)
    );

    assign result_valid = out_valid_reg;
    assign first_red    = colors[6*CHAN_W-1 -: CHAN_W];
    assign first_green  = colors[5*CHAN_W-1 -: CHAN_W];
    assign first_blue   = colors[4*CHAN_W-1 -: CHAN_W];
    assign second_red   = colors[3*CHAN_W-1 -: CHAN_W];
    assign second_green = colors[2*CHAN_W-1 -: CHAN_W];
    assign second_blue  = colors[CHAN_W-1 -: CHAN_W];

`ifndef SYNTHESIS
    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ({1'b0, palette_index} < (INDEX_W + 1)'(PALETTE_ENTRIES)))
        else $error("palette index beyond palette size");

    a_accept_fills_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> step_valid_reg)
        else $error("accepted tick lost in step stage");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        tick_stall |-> (step_valid_reg && mix_valid_reg && out_valid_reg && result_stall))
        else $error("tick stalled with room in pipeline");

    a_word_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && !mix_valid_reg) |=> !result_valid)
        else $error("result word repeated");
`endif

endmodule

### tb/palette_hold_and_crossfade_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_hold_and_crossfade_test
// Sends elapsed-time ticks into the palette crossfade block and compares
// every color word with an independent prediction of the hold and fade
// phases, across several hold_time settings written over the APB port.
// ----------------------------------------------------------------------------
module palette_hold_and_crossfade_test;
    import pcf_pkg::*;

    localparam logic [APB_ADDR_W-1:0] HOLD_TIME_ADDR = {REG_HOLD_TIME, 2'b00};
    localparam int IDLE_PERCENT = 11;
    localparam int STALL_LIMIT  = 1000;
    localparam int PHASES       = 10;
    localparam int PHASE_TICKS  = 125;

    typedef struct packed {
        logic [CHAN_W-1:0]  first_red;
        logic [CHAN_W-1:0]  first_green;
        logic [CHAN_W-1:0]  first_blue;
        logic [CHAN_W-1:0]  second_red;
        logic [CHAN_W-1:0]  second_green;
        logic [CHAN_W-1:0]  second_blue;
        logic               fading;
        logic [INDEX_W-1:0] palette_index;
    } stripe_word_t;

    class crossfade_scoreboard;
        logic [HOLD_W-1:0]  hold_ms;
        logic [TIMER_W-1:0] ms_in_phase;
        bit                 in_fade;
        logic [INDEX_W-1:0] shown_entry;
        stripe_word_t       pending[$];
        int                 errors;

        function new();
            hold_ms     = HOLD_W'(HOLD_RESET);
            ms_in_phase = '0;
            in_fade     = 1'b0;
            shown_entry = '0;
            errors      = 0;
        endfunction

        function void set_hold(logic [HOLD_W-1:0] value);
            hold_ms = value;
        endfunction

        function int outstanding();
            return pending.size();
        endfunction

        // {first r, g, b, second r, g, b}
        function logic [6*CHAN_W-1:0] color_pair(int slot);
            case (slot)
                0: return {8'd184, 8'd0,   8'd184, 8'd107, 8'd0,   8'd184};
                1: return {8'd107, 8'd0,   8'd184, 8'd31,  8'd0,   8'd184};
                2: return {8'd31,  8'd0,   8'd184, 8'd0,   8'd46,  8'd184};
                3: return {8'd0,   8'd46,  8'd184, 8'd0,   8'd123, 8'd184};
                4: return {8'd0,   8'd123, 8'd184, 8'd0,   8'd184, 8'd169};
                5: return {8'd7,   8'd154, 8'd90,  8'd46,  8'd184, 8'd82};
                6: return {8'd169, 8'd184, 8'd0,   8'd184, 8'd123, 8'd0};
                7: return {8'd184, 8'd123, 8'd0,   8'd184, 8'd46,  8'd0};
                8: return {8'd184, 8'd46,  8'd0,   8'd184, 8'd0,   8'd31};
                default: return {8'd184, 8'd28, 8'd70, 8'd154, 8'd0, 8'd89};
            endcase
        endfunction

        function logic [INDEX_W-1:0] following_entry(logic [INDEX_W-1:0] entry);
            logic [INDEX_W:0] bumped;
            bumped = {1'b0, entry} + 1'b1;
            bumped[INDEX_W] = 1'b0;
            return (bumped >= PALETTE_ENTRIES) ? '0 : bumped[INDEX_W-1:0];
        endfunction

        function void note_tick(logic [DT_W-1:0] dt);
            int unsigned          total;
            int unsigned          t;
            int unsigned          k;
            int unsigned          mixed;
            bit                   blend;
            logic [6*CHAN_W-1:0]  cur_pair;
            logic [6*CHAN_W-1:0]  nxt_pair;
            logic [CHAN_W-1:0]    chan [CHANNELS];
            stripe_word_t         word;

            total = ms_in_phase + dt;
            if (total > TIMER_MAX)
                total = TIMER_MAX;
            ms_in_phase = total[TIMER_W-1:0];
            blend = 1'b0;
            if (!in_fade)
            begin
                if (ms_in_phase > hold_ms)
                begin
                    ms_in_phase = '0;
                    in_fade     = 1'b1;
                end
            end
            else if (ms_in_phase > FADE_MS)
            begin
                ms_in_phase = '0;
                in_fade     = 1'b0;
                shown_entry = following_entry(shown_entry);
            end
            else
                blend = 1'b1;

            cur_pair = color_pair(shown_entry % ROM_SIZE);
            nxt_pair = color_pair(following_entry(shown_entry) % ROM_SIZE);
            t = ms_in_phase;
            k = FADE_MS - t;
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                mixed = cur_pair[6*CHAN_W-1-CHAN_W*ch -: CHAN_W];
                if (blend)
                    mixed = (mixed * k + nxt_pair[6*CHAN_W-1-CHAN_W*ch -: CHAN_W] * t)
                            / FADE_MS;
                chan[ch] = mixed[CHAN_W-1:0];
            end
            word.first_red     = chan[0];
            word.first_green   = chan[1];
            word.first_blue    = chan[2];
            word.second_red    = chan[3];
            word.second_green  = chan[4];
            word.second_blue   = chan[5];
            word.fading        = in_fade;
            word.palette_index = shown_entry;
            pending = {pending, word};
        endfunction

        function void compare_field(string what, int want, int seen);
            if (want != seen)
            begin
                errors++;
                $display("%0t: %s expected %0d got %0d", $time, what, want, seen);
            end
        endfunction

        function void check_word(stripe_word_t got);
            stripe_word_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: word with no tick waiting, expected none got index %0d",
                         $time, got.palette_index);
                return;
            end
            want = pending.pop_front();
            compare_field("first_red",     want.first_red,     got.first_red);
            compare_field("first_green",   want.first_green,   got.first_green);
            compare_field("first_blue",    want.first_blue,    got.first_blue);
            compare_field("second_red",    want.second_red,    got.second_red);
            compare_field("second_green",  want.second_green,  got.second_green);
            compare_field("second_blue",   want.second_blue,   got.second_blue);
            compare_field("fading",        want.fading,        got.fading);
            compare_field("palette_index", want.palette_index, got.palette_index);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  tick_valid;
    logic                  tick_stall;
    logic [DT_W-1:0]       elapsed_ms;
    logic                  result_valid;
    logic                  result_stall;
    logic [CHAN_W-1:0]     first_red;
    logic [CHAN_W-1:0]     first_green;
    logic [CHAN_W-1:0]     first_blue;
    logic [CHAN_W-1:0]     second_red;
    logic [CHAN_W-1:0]     second_green;
    logic [CHAN_W-1:0]     second_blue;
    logic                  fading;
    logic [INDEX_W-1:0]    palette_index;

    crossfade_scoreboard sb;
    bit                  no_idle;
    int                  quiet_cycles;

    palette_hold_and_crossfade u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .tick_valid    (tick_valid),
        .tick_stall    (tick_stall),
        .elapsed_ms    (elapsed_ms),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .first_red     (first_red),
        .first_green   (first_green),
        .first_blue    (first_blue),
        .second_red    (second_red),
        .second_green  (second_green),
        .second_blue   (second_blue),
        .fading        (fading),
        .palette_index (palette_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // word sink with random stalls
    initial
    begin
        stripe_word_t got;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_valid === 1'b1 && result_stall === 1'b0)
            begin
                got.first_red     = first_red;
                got.first_green   = first_green;
                got.first_blue    = first_blue;
                got.second_red    = second_red;
                got.second_green  = second_green;
                got.second_blue   = second_blue;
                got.fading        = fading;
                got.palette_index = palette_index;
                sb.check_word(got);
            end
            result_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // watchdog on cycles where no word moves on either side
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((tick_valid === 1'b1 && tick_stall === 1'b0) ||
                (result_valid === 1'b1 && result_stall === 1'b0))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic send_tick(input logic [DT_W-1:0] dt);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            tick_valid <= 1'b0;
            @(posedge clk);
        end
        tick_valid <= 1'b1;
        elapsed_ms <= dt;
        do
            @(posedge clk);
        while (tick_stall !== 1'b0);
        sb.note_tick(dt);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
    endtask

    task automatic write_register(input logic [APB_ADDR_W-1:0] addr,
                                  input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic read_register(input logic [APB_ADDR_W-1:0] addr,
                                 output logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // only while nothing is in flight; the pipeline holds the step, mix and result registers
    task automatic program_hold(input logic [HOLD_W-1:0] value);
        logic [APB_DATA_W-1:0] readback;
        tick_valid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge clk);
        write_register(HOLD_TIME_ADDR, {{(APB_DATA_W-HOLD_W){1'b0}}, value});
        @(posedge clk);
        read_register(HOLD_TIME_ADDR, readback);
        sb.compare_field("hold_time readback", value, readback[HOLD_W-1:0]);
        sb.set_hold(value);
    endtask

    initial
    begin
        // reset hold: reach exactly the hold time, cross it, fade to exactly
        // the fade length, then cross into the next entry
        int                    reset_hold_ticks [11] = '{0, 1023, 1023, 954, 1, 1000,
                                                         1000, 0, 1, 0, 512};
        // zero hold: no time stays in hold, any nonzero time starts a fade
        int                    zero_hold_ticks [8]   = '{0, 1, 1023, 977, 1023, 1023,
                                                         1023, 1023};
        logic [APB_DATA_W-1:0] readback;
        logic [HOLD_W-1:0]     hold_pick;
        logic [DT_W-1:0]       dt;
        int                    mode;

        rst_n      <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        tick_valid <= 1'b0;
        elapsed_ms <= '0;
        no_idle    <= 1'b0;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        read_register(HOLD_TIME_ADDR, readback);
        sb.compare_field("hold_time after reset", HOLD_RESET, readback[HOLD_W-1:0]);
        @(posedge clk);

        foreach (reset_hold_ticks[i])
            send_tick(DT_W'(reset_hold_ticks[i]));
        program_hold('0);
        foreach (zero_hold_ticks[i])
            send_tick(DT_W'(zero_hold_ticks[i]));

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: hold_pick = '1;
                1: hold_pick = '0;
                2: hold_pick = HOLD_W'(1);
                3: hold_pick = HOLD_W'(FADE_MS);
                4: hold_pick = HOLD_W'(HOLD_RESET);
                5: hold_pick = HOLD_W'($urandom_range(0, 65535));
                6: hold_pick = HOLD_W'($urandom_range(0, 255));
                7: hold_pick = '0;
                default: hold_pick = HOLD_W'($urandom_range(0, 4095));
            endcase
            program_hold(hold_pick);
            no_idle <= (phase == 4);
            for (int n = 0; n < PHASE_TICKS; n++)
            begin
                if (phase == 3 && n == PHASE_TICKS / 2)
                begin
                    tick_valid <= 1'b0;
                    wait_drained();
                end
                mode = $urandom_range(0, 99);
                if (mode < 10)
                    dt = '0;
                else if (mode < 25)
                    dt = '1;
                else if (mode < 50)
                    dt = DT_W'($urandom_range(0, 63));
                else
                    dt = DT_W'($urandom_range(0, 1023));
                send_tick(dt);
            end
        end

        tick_valid <= 1'b0;
        no_idle    <= 1'b0;
        wait_drained();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
rtl/pcf_pkg.sv
rtl/pcf_sequencer.sv
rtl/pcf_blend.sv
rtl/palette_hold_and_crossfade.sv
tb/palette_hold_and_crossfade_test.sv
